/* hw/rtl/rrbm_pkg.sv */
// Package for the ROM/RAM bank mapper: region codes, read source codes,
// the pipeline stage record and fixed sizes of the bus windows.
// Used by rom_ram_bank_mapper; depends on nothing else.
`default_nettype none

package rrbm_pkg;

   // Fixed geometry of the bus map.
   localparam int RomBankBytes = 16384;
   localparam int RomOffsetW   = 14;
   localparam int RomBankW     = 7;
   localparam int RomAddrW     = RomBankW + RomOffsetW;
   localparam int RamWindow    = 8192;
   localparam int RamOffsetW   = 13;

   // Default and top of the bank count and cart RAM bank count.
   localparam int MaxRomBanks     = 128;
   localparam int CartRamBanksDef = 4;

   localparam logic [3:0] RamEnableKey = 4'hA;

   typedef enum logic [2:0] {
      REGION_ROM     = 3'd0,
      REGION_VRAM    = 3'd1,
      REGION_CART    = 3'd2,
      REGION_WRAM    = 3'd3,
      REGION_CONTROL = 3'd4
   } region_type;

   typedef enum logic [2:0] {
      RD_ZERO = 3'd0,
      RD_FF   = 3'd1,
      RD_VRAM = 3'd2,
      RD_CART = 3'd3,
      RD_WRAM = 3'd4
   } rd_src_type;

   // One access on its way from the memory read to the result register.
   typedef struct packed {
      logic                valid;
      rd_src_type          rd_src;
      logic                rom_fetch;
      logic [RomAddrW-1:0] rom_address;
      region_type          region;
   } stage_type;

endpackage : rrbm_pkg

`default_nettype wire

/* hw/rtl/rom_ram_bank_mapper.sv */
// Top level of the ROM/RAM bank mapper: bank registers, video, work and
// cart RAM, and a two-stage path from the request to the response.
// Depends on rrbm_pkg.
//
//   channel   dir  beat contents (low bit first)
//   req_*     in   tuser: op; tdata: address[15:0], write_data[23:16]
//   rsp_*     out  tuser: rom_fetch, region[3:1]; tdata: read_data[7:0],
//                  rom_address[28:8]
//   csr_*     in   csr_wdata: rom_size_code, written when csr_we is high
//
// An accepted request is registered in the RAM read stage and then in the
// response register; a new request may be accepted every cycle while the
// response is taken. The RAMs are read synchronously into the first stage.
// A stalled response holds the pipeline; requests are refused only when
// both the RAM read stage and the response register are full.
// Reset clears the bank registers and the pipeline; RAM contents are left
// as they are and need no clearing pass.
`default_nettype none

module rom_ram_bank_mapper #(
   parameter int CART_RAM_BANKS = rrbm_pkg::CartRamBanksDef
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [0:0]  req_tuser,   // op
   input  wire logic [23:0] req_tdata,   // address, write_data

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [3:0]       rsp_tuser,   // rom_fetch, region
   output logic [31:0]      rsp_tdata,   // read_data, rom_address, zero pad

   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_wdata
);

   localparam int CartDepth = CART_RAM_BANKS * rrbm_pkg::RamWindow;
   localparam int CartAw    = $clog2(CartDepth);
   localparam int RamAw     = rrbm_pkg::RamOffsetW;
   localparam int BankW     = rrbm_pkg::RomBankW;
   localparam int MaxBanks  = rrbm_pkg::MaxRomBanks;

   // ------------------------------------------------------------------
   // Configuration and bank registers
   // ------------------------------------------------------------------
   logic [2:0] rom_size_code_ff;
   logic       ram_enabled_ff, ram_enabled_in;
   logic [4:0] low_rom_bank_ff, low_rom_bank_in;
   logic [1:0] upper_bank_ff, upper_bank_in;
   logic       banking_mode_ff, banking_mode_in;

   // Request fields
   logic        req_op;
   logic [15:0] req_addr;
   logic [7:0]  req_wdata;
   logic        req_fire;

   assign req_op    = req_tuser[0];
   assign req_addr  = req_tdata[15:0];
   assign req_wdata = req_tdata[23:16];
   assign req_fire  = req_tvalid & req_tready;

   // ------------------------------------------------------------------
   // ROM bank mapping
   // ------------------------------------------------------------------
   // Remainders by the largest bank count, fixed at elaboration; used when
   // the bank count saturates, which need not be a power of two.
   logic [BankW-1:0] mod_tab [2**BankW];

   for (genvar gi = 0; gi < 2**BankW; gi++) begin : g_mod
      assign mod_tab[gi] = BankW'(gi % MaxBanks);
   end

   logic [8:0]       n_raw;
   logic [8:0]       n_eff;
   logic             n_capped;
   logic             n_large;
   logic [BankW-1:0] n_mask;
   logic [4:0]       low_eff;
   logic [BankW-1:0] win0_raw, win1_raw;
   logic [BankW-1:0] win0_bank, win1_bank, rom_bank;

   always_comb begin
      n_raw    = 9'd2 << rom_size_code_ff;
      n_capped = n_raw >= 9'(MaxBanks);
      n_eff    = n_capped ? 9'(MaxBanks) : n_raw;
      n_large  = n_eff > 9'd32;
      n_mask   = BankW'(n_eff - 9'd1);
      low_eff  = (low_rom_bank_ff == 5'd0) ? 5'd1 : low_rom_bank_ff;

      win0_raw = (n_large && banking_mode_ff) ? {upper_bank_ff, 5'd0} : '0;
      win1_raw = n_large ? {upper_bank_ff, low_eff} : {2'b00, low_eff};

      win0_bank = n_capped ? mod_tab[win0_raw] : (win0_raw & n_mask);
      win1_bank = n_capped ? mod_tab[win1_raw] : (win1_raw & n_mask);
      rom_bank  = req_addr[14] ? win1_bank : win0_bank;
   end

   // ------------------------------------------------------------------
   // Cart RAM bank: upper bank in mode 1, reduced below CART_RAM_BANKS.
   // ------------------------------------------------------------------
   logic [1:0]  cart_bank;
   logic [14:0] cart_index_full;
   logic [CartAw-1:0] cart_index;

   always_comb begin
      cart_bank = banking_mode_ff ? upper_bank_ff : 2'd0;
      for (int i = 0; i < 3; i++) begin
         if (3'(cart_bank) >= 3'(CART_RAM_BANKS)) begin
            cart_bank = 2'(3'(cart_bank) - 3'(CART_RAM_BANKS));
         end
      end
      cart_index_full = {cart_bank, req_addr[RamAw-1:0]};
      cart_index      = cart_index_full[CartAw-1:0];
   end

   // ------------------------------------------------------------------
   // Decode of the accepted beat
   // ------------------------------------------------------------------
   rrbm_pkg::stage_type s1_ff, s1_in;
   rrbm_pkg::stage_type out_ff, out_in;
   logic [7:0] rd_data_in;
   logic       s1_advance;
   logic       vram_we, wram_we, cart_we;

   always_comb begin
      ram_enabled_in  = ram_enabled_ff;
      low_rom_bank_in = low_rom_bank_ff;
      upper_bank_in   = upper_bank_ff;
      banking_mode_in = banking_mode_ff;
      vram_we = 1'b0;
      wram_we = 1'b0;
      cart_we = 1'b0;

      s1_in             = s1_ff;
      s1_in.rd_src      = rrbm_pkg::RD_ZERO;
      s1_in.rom_fetch   = 1'b0;
      s1_in.rom_address = '0;
      s1_in.region      = rrbm_pkg::REGION_CONTROL;

      case (req_addr[15:13])
         3'b000, 3'b001, 3'b010, 3'b011: begin
            if (req_op) begin
               case (req_addr[14:13])
                  2'b00: ram_enabled_in =
                     (req_wdata[3:0] == rrbm_pkg::RamEnableKey);
                  2'b01: low_rom_bank_in =
                     (req_wdata[4:0] == 5'd0) ? 5'd1 : req_wdata[4:0];
                  2'b10: upper_bank_in = req_wdata[1:0];
                  default: banking_mode_in = req_wdata[0];
               endcase
            end else begin
               s1_in.region      = rrbm_pkg::REGION_ROM;
               s1_in.rom_fetch   = 1'b1;
               s1_in.rom_address = {rom_bank, req_addr[rrbm_pkg::RomOffsetW-1:0]};
            end
         end
         3'b100: begin
            s1_in.region = rrbm_pkg::REGION_VRAM;
            vram_we      = req_op;
            if (!req_op) s1_in.rd_src = rrbm_pkg::RD_VRAM;
         end
         3'b101: begin
            s1_in.region = rrbm_pkg::REGION_CART;
            if (ram_enabled_ff) begin
               cart_we = req_op;
               if (!req_op) s1_in.rd_src = rrbm_pkg::RD_CART;
            end else if (!req_op) begin
               s1_in.rd_src = rrbm_pkg::RD_FF;
            end
         end
         3'b110: begin
            s1_in.region = rrbm_pkg::REGION_WRAM;
            wram_we      = req_op;
            if (!req_op) s1_in.rd_src = rrbm_pkg::RD_WRAM;
         end
         default: begin
            s1_in.region = rrbm_pkg::REGION_CONTROL;
         end
      endcase

      if (req_fire) begin
         s1_in.valid = 1'b1;
      end else begin
         s1_in       = s1_ff;
         s1_in.valid = s1_ff.valid & ~s1_advance;
         ram_enabled_in  = ram_enabled_ff;
         low_rom_bank_in = low_rom_bank_ff;
         upper_bank_in   = upper_bank_ff;
         banking_mode_in = banking_mode_ff;
      end
   end

   // ------------------------------------------------------------------
   // RAMs: a read on every accepted beat and a write on a write beat, read data registered.
   // The read data registers load only on acceptance, so they hold while
   // the beat waits in the first stage.
   // ------------------------------------------------------------------
   logic [7:0] vram_mem [rrbm_pkg::RamWindow];
   logic [7:0] wram_mem [rrbm_pkg::RamWindow];
   logic [7:0] cart_mem [CartDepth];
   logic [7:0] vram_q_ff, wram_q_ff, cart_q_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         if (vram_we) vram_mem[req_addr[RamAw-1:0]] <= req_wdata;
         vram_q_ff <= vram_mem[req_addr[RamAw-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         if (wram_we) wram_mem[req_addr[RamAw-1:0]] <= req_wdata;
         wram_q_ff <= wram_mem[req_addr[RamAw-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         if (cart_we) cart_mem[cart_index] <= req_wdata;
         cart_q_ff <= cart_mem[cart_index];
      end
   end

   // ------------------------------------------------------------------
   // Response register
   // ------------------------------------------------------------------
   logic [7:0] rd_data_ff;

   assign s1_advance = s1_ff.valid & (~out_ff.valid | rsp_tready);
   assign req_tready = ~s1_ff.valid | s1_advance;

   always_comb begin
      case (s1_ff.rd_src)
         rrbm_pkg::RD_FF:   rd_data_in = 8'hFF;
         rrbm_pkg::RD_VRAM: rd_data_in = vram_q_ff;
         rrbm_pkg::RD_CART: rd_data_in = cart_q_ff;
         rrbm_pkg::RD_WRAM: rd_data_in = wram_q_ff;
         default:           rd_data_in = 8'h00;
      endcase

      out_in = out_ff;
      if (s1_advance) begin
         out_in = s1_ff;
      end else if (rsp_tready) begin
         out_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) rd_data_ff <= rd_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_size_code_ff <= 3'd0;
         ram_enabled_ff   <= 1'b0;
         low_rom_bank_ff  <= 5'd0;
         upper_bank_ff    <= 2'd0;
         banking_mode_ff  <= 1'b0;
         s1_ff.valid      <= 1'b0;
         out_ff.valid     <= 1'b0;
      end else begin
         if (csr_we) rom_size_code_ff <= csr_wdata;
         ram_enabled_ff  <= ram_enabled_in;
         low_rom_bank_ff <= low_rom_bank_in;
         upper_bank_ff   <= upper_bank_in;
         banking_mode_ff <= banking_mode_in;
         s1_ff.valid     <= s1_in.valid;
         out_ff.valid    <= out_in.valid;
      end

      // Payload of the pipeline stages needs no reset.
      s1_ff.rd_src       <= s1_in.rd_src;
      s1_ff.rom_fetch    <= s1_in.rom_fetch;
      s1_ff.rom_address  <= s1_in.rom_address;
      s1_ff.region       <= s1_in.region;
      out_ff.rd_src      <= out_in.rd_src;
      out_ff.rom_fetch   <= out_in.rom_fetch;
      out_ff.rom_address <= out_in.rom_address;
      out_ff.region      <= out_in.region;
   end

   assign rsp_tvalid = out_ff.valid;
   assign rsp_tuser  = {out_ff.region, out_ff.rom_fetch};
   assign rsp_tdata  = {3'b000, out_ff.rom_address, rd_data_ff};

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_rom_read_fetches: assert property (@(posedge clock) disable iff (reset)
      req_fire && !req_op && !req_addr[15] |=> s1_ff.valid && s1_ff.rom_fetch)
      else $error("ROM read did not produce a fetch");

   a_low_bank_nonzero: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_op && req_addr[15:13] == 3'b001 |=> low_rom_bank_ff != 5'd0)
      else $error("ROM bank register holds zero after a bank write");

   a_stage_kept: assert property (@(posedge clock) disable iff (reset)
      s1_ff.valid && !s1_advance |=> s1_ff.valid && $stable(s1_ff.rom_address))
      else $error("stalled beat lost in the RAM read stage");

   a_cart_bank_range: assert property (@(posedge clock) disable iff (reset)
      req_fire && cart_we |-> 3'(cart_bank) < 3'(CART_RAM_BANKS))
      else $error("cart RAM bank out of range");

endmodule : rom_ram_bank_mapper

`default_nettype wire
